>>> rtl/iptcd_pkg.sv
`timescale 1ns / 1ps

package iptcd_pkg;

  localparam int SigLen = 14;
  localparam int TagLen = 4;
  localparam int QueueDepth = 4;
  localparam int QueueAw = $clog2(QueueDepth);

  localparam logic [15:0] WANTED_ID_RESET = 16'h0404;
  localparam logic [7:0]  DATASET_MARKER  = 8'h1C;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_BAD_SIG = 2'd1,
    ST_NONE    = 2'd2,
    ST_MARKER  = 2'd3
  } status_t;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] category;
    logic [7:0] number;
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    logic       has_summary;
    status_t    status;
  } iptcd_cmd_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    case (idx)
      4'd0:    sig_byte = 8'h50;
      4'd1:    sig_byte = 8'h68;
      4'd2:    sig_byte = 8'h6F;
      4'd3:    sig_byte = 8'h74;
      4'd4:    sig_byte = 8'h6F;
      4'd5:    sig_byte = 8'h73;
      4'd6:    sig_byte = 8'h68;
      4'd7:    sig_byte = 8'h6F;
      4'd8:    sig_byte = 8'h70;
      4'd9:    sig_byte = 8'h20;
      4'd10:   sig_byte = 8'h33;
      4'd11:   sig_byte = 8'h2E;
      4'd12:   sig_byte = 8'h30;
      default: sig_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    tag_byte = 8'h38;
      2'd1:    tag_byte = 8'h42;
      2'd2:    tag_byte = 8'h49;
      default: tag_byte = 8'h4D;
    endcase
  endfunction

endpackage

>>> rtl/iptcd_front.sv
`timescale 1ns / 1ps

module iptcd_front
  import iptcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  output logic        push,
  output iptcd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    PH_SIG, PH_TAG, PH_ID, PH_NAMELEN, PH_NAME, PH_SIZE, PH_SKIP,
    PH_MARK, PH_CAT, PH_NUM, PH_LENHI, PH_LENLO, PH_DATA, PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] wanted_id;
  logic [7:0]  field_count, field_count_next;
  logic [15:0] resource_id, resource_id_next;
  logic [15:0] block_left, block_left_next;
  logic [15:0] dataset_left, dataset_left_next;
  logic [7:0]  cur_category, cur_category_next;
  logic [7:0]  cur_dataset, cur_dataset_next;
  logic        found_flag, found_flag_next;
  status_t     error_code, error_code_next;

  logic        consume_en;
  phase_t      consume_to;
  logic [15:0] bl_dec, dl_dec, size_new;
  logic [7:0]  fc_inc;
  logic        id_match;

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    resource_id_next  = resource_id;
    block_left_next   = block_left;
    dataset_left_next = dataset_left;
    cur_category_next = cur_category;
    cur_dataset_next  = cur_dataset;
    found_flag_next   = found_flag;
    error_code_next   = error_code;
    consume_en        = 1'b0;
    consume_to        = PH_SKIP;
    bl_dec            = block_left - 16'd1;
    dl_dec            = dataset_left - 16'd1;
    fc_inc            = field_count + 8'd1;
    size_new          = {block_left[7:0], in_byte};
    id_match          = (resource_id == wanted_id);
    cmd               = '0;
    cmd.category      = cur_category;
    cmd.number        = cur_dataset;
    cmd.status        = ST_FOUND;

    if (accept) begin
      case (phase)
        PH_SIG: begin
          if (field_count >= 8'(SigLen) || in_byte != sig_byte(field_count[3:0])) begin
            error_code_next = ST_BAD_SIG;
            phase_next      = PH_IDLE;
          end else if (fc_inc == 8'(SigLen)) begin
            field_count_next = '0;
            phase_next       = PH_TAG;
          end else begin
            field_count_next = fc_inc;
          end
        end
        PH_TAG: begin
          if (in_byte != tag_byte(field_count[1:0])) begin
            phase_next = PH_IDLE;
          end else if (fc_inc >= 8'(TagLen)) begin
            field_count_next = '0;
            resource_id_next = '0;
            phase_next       = PH_ID;
          end else begin
            field_count_next = fc_inc;
          end
        end
        PH_ID: begin
          resource_id_next = {resource_id[7:0], in_byte};
          if (fc_inc >= 8'd2) begin
            field_count_next = '0;
            phase_next       = PH_NAMELEN;
          end else begin
            field_count_next = fc_inc;
          end
        end
        PH_NAMELEN: begin
          field_count_next = in_byte | 8'd1;
          phase_next       = PH_NAME;
        end
        PH_NAME: begin
          field_count_next = field_count - 8'd1;
          if (field_count == 8'd1) begin
            block_left_next = '0;
            phase_next      = PH_SIZE;
          end
        end
        PH_SIZE: begin
          block_left_next = size_new;
          if (fc_inc >= 8'd2) begin
            field_count_next = '0;
            if (id_match) begin
              found_flag_next = 1'b1;
            end
            if (size_new == 16'd0) begin
              phase_next = PH_TAG;
            end else begin
              phase_next = id_match ? PH_MARK : PH_SKIP;
            end
          end else begin
            field_count_next = fc_inc;
          end
        end
        PH_SKIP: begin
          consume_en = 1'b1;
          consume_to = PH_SKIP;
        end
        PH_MARK: begin
          consume_en = 1'b1;
          if (in_byte != DATASET_MARKER) begin
            if (error_code == ST_FOUND) begin
              error_code_next = ST_MARKER;
            end
            consume_to = PH_SKIP;
          end else begin
            consume_to = PH_CAT;
          end
        end
        PH_CAT: begin
          cur_category_next = in_byte;
          consume_en        = 1'b1;
          consume_to        = PH_NUM;
        end
        PH_NUM: begin
          cur_dataset_next = in_byte;
          consume_en       = 1'b1;
          consume_to       = PH_LENHI;
        end
        PH_LENHI: begin
          dataset_left_next = {in_byte, 8'h00};
          consume_en        = 1'b1;
          consume_to        = PH_LENLO;
        end
        PH_LENLO: begin
          dataset_left_next = {dataset_left[15:8], in_byte};
          consume_en        = 1'b1;
          if ({dataset_left[15:8], in_byte} == 16'd0) begin
            cmd.has_payload = 1'b1;
            cmd.last        = 1'b1;
            consume_to      = PH_MARK;
          end else begin
            consume_to = PH_DATA;
          end
        end
        PH_DATA: begin
          dataset_left_next = dl_dec;
          cmd.has_payload   = 1'b1;
          cmd.data          = in_byte;
          cmd.data_valid    = 1'b1;
          cmd.last          = (dl_dec == 16'd0) || (block_left == 16'd1);
          consume_en        = 1'b1;
          consume_to        = (dl_dec == 16'd0) ? PH_MARK : PH_DATA;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (consume_en) begin
        block_left_next = bl_dec;
        if (bl_dec == 16'd0) begin
          phase_next       = PH_TAG;
          field_count_next = '0;
        end else begin
          phase_next = consume_to;
        end
      end

      if (end_of_buffer) begin
        cmd.has_summary = 1'b1;
        if (phase_next == PH_SIG || error_code_next == ST_BAD_SIG) begin
          cmd.status = ST_BAD_SIG;
        end else if (error_code_next == ST_MARKER) begin
          cmd.status = ST_MARKER;
        end else if (found_flag_next) begin
          cmd.status = ST_FOUND;
        end else begin
          cmd.status = ST_NONE;
        end
        phase_next        = PH_SIG;
        field_count_next  = '0;
        resource_id_next  = '0;
        block_left_next   = '0;
        dataset_left_next = '0;
        cur_category_next = '0;
        cur_dataset_next  = '0;
        found_flag_next   = 1'b0;
        error_code_next   = ST_FOUND;
      end
    end
  end

  assign push = cmd.has_payload | cmd.has_summary;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_id    <= WANTED_ID_RESET;
      phase        <= PH_SIG;
      field_count  <= '0;
      resource_id  <= '0;
      block_left   <= '0;
      dataset_left <= '0;
      cur_category <= '0;
      cur_dataset  <= '0;
      found_flag   <= 1'b0;
      error_code   <= ST_FOUND;
    end else begin
      if (cfg_we) begin
        wanted_id <= cfg_wdata;
      end
      phase        <= phase_next;
      field_count  <= field_count_next;
      resource_id  <= resource_id_next;
      block_left   <= block_left_next;
      dataset_left <= dataset_left_next;
      cur_category <= cur_category_next;
      cur_dataset  <= cur_dataset_next;
      found_flag   <= found_flag_next;
      error_code   <= error_code_next;
    end
  end

endmodule

>>> rtl/iptcd_fifo.sv
`timescale 1ns / 1ps

module iptcd_fifo
  import iptcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  iptcd_cmd_t push_cmd,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output iptcd_cmd_t pop_cmd
);

  iptcd_cmd_t           entries [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr, rd_ptr;
  logic [QueueAw:0]     count;

  assign full      = (count == (QueueAw+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + QueueAw'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + QueueAw'(1);
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + (QueueAw+1)'(1);
        2'b01:   count <= count - (QueueAw+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/iptcd_back.sv
`timescale 1ns / 1ps

module iptcd_back
  import iptcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  iptcd_cmd_t  q_cmd,
  output logic        q_pop,
  output logic        valid,
  input  logic        ready,
  output logic        is_summary,
  output logic [7:0]  record_category,
  output logic [7:0]  dataset_number,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        dataset_end,
  output logic [1:0]  parse_status
);

  iptcd_cmd_t cur;
  logic       cur_valid;
  logic       payload_sent;
  logic       show_payload;
  logic       finishing;

  assign show_payload = cur.has_payload && !payload_sent;
  assign finishing    = cur_valid && ready && (!show_payload || !cur.has_summary);
  assign q_pop        = q_not_empty && (!cur_valid || finishing);

  assign valid           = cur_valid;
  assign is_summary      = !show_payload;
  assign record_category = show_payload ? cur.category : 8'd0;
  assign dataset_number  = show_payload ? cur.number : 8'd0;
  assign payload_byte    = show_payload ? cur.data : 8'd0;
  assign payload_valid   = show_payload && cur.data_valid;
  assign dataset_end     = show_payload && cur.last;
  assign parse_status    = show_payload ? ST_FOUND : cur.status;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      payload_sent <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid    <= 1'b1;
        payload_sent <= 1'b0;
      end else if (finishing) begin
        cur_valid    <= 1'b0;
        payload_sent <= 1'b0;
      end else if (cur_valid && ready && show_payload) begin
        payload_sent <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/image_resource_iptc_deframer_core.sv
`timescale 1ns / 1ps

// IPTC dataset deframer for image resource blocks. Bytes of a metadata buffer
// enter one per cycle while byte_ready is high; after the 14-byte signature the
// resource blocks are walked and the block whose id equals the register written
// through cfg_we/cfg_wdata (reset 0x0404) is split into datasets, one result
// word per payload byte (one word with payload_valid low for an empty dataset).
// The byte marked end_of_buffer also yields a status word and restarts parsing.
// A byte is taken every cycle while the four-entry command queue between the
// parser and the output stage has room; the output stage delivers one word per
// cycle while result_ready is high, payload word before status word. Each command
// is registered in the queue and then in the output stage before it is shown.
module image_resource_iptc_deframer_core
  import iptcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        is_summary,
  output logic [7:0]  record_category,
  output logic [7:0]  dataset_number,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        dataset_end,
  output logic [1:0]  parse_status
);

  iptcd_cmd_t push_cmd, pop_cmd;
  logic       push, full, pop, not_empty, accept;

  assign byte_ready = !full;
  assign accept     = byte_valid && byte_ready;

  iptcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_buffer(end_of_buffer),
    .push         (push),
    .cmd          (push_cmd)
  );

  iptcd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .not_empty(not_empty),
    .pop_cmd  (pop_cmd)
  );

  iptcd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (not_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (pop),
    .valid          (result_valid),
    .ready          (result_ready),
    .is_summary     (is_summary),
    .record_category(record_category),
    .dataset_number (dataset_number),
    .payload_byte   (payload_byte),
    .payload_valid  (payload_valid),
    .dataset_end    (dataset_end),
    .parse_status   (parse_status)
  );

endmodule

>>> tb/sv/image_resource_iptc_deframer_core_test.sv
`timescale 1ns / 1ps

module image_resource_iptc_deframer_core_test;
  import iptcd_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int CycleLimit = 250000;
  localparam int DrainCycles = 12;
  localparam int BytesPerSetting = 180;
  localparam logic [111:0] SIG_TEXT = 112'h50686F746F73686F7020332E3000;
  localparam logic [31:0] TAG_TEXT = 32'h3842494D;

  typedef enum logic [3:0] {
    S_SIGNATURE, S_TAG, S_ID, S_NAME_LEN, S_NAME, S_SIZE, S_SKIP,
    S_MARKER, S_CATEGORY, S_NUMBER, S_LEN_HI, S_LEN_LO, S_DATA, S_IGNORE
  } parser_phase_t;

  typedef struct packed {
    logic       summ;
    logic [7:0] cat;
    logic [7:0] num;
    logic [7:0] data;
    logic       pv;
    logic       de;
    status_t    st;
  } deframe_word_t;

  typedef struct {
    logic [7:0] b;
    logic       eob;
  } buffer_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  in_byte;
  logic        end_of_buffer;
  logic        result_valid;
  logic        result_ready;
  logic        is_summary;
  logic [7:0]  record_category;
  logic [7:0]  dataset_number;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        dataset_end;
  logic [1:0]  parse_status;

  image_resource_iptc_deframer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .in_byte        (in_byte),
    .end_of_buffer  (end_of_buffer),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .is_summary     (is_summary),
    .record_category(record_category),
    .dataset_number (dataset_number),
    .payload_byte   (payload_byte),
    .payload_valid  (payload_valid),
    .dataset_end    (dataset_end),
    .parse_status   (parse_status)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // parser copy
  logic [15:0]   wanted_id;
  parser_phase_t ph;
  logic [7:0]    fcount;
  logic [15:0]   rid;
  logic [15:0]   blk_left;
  logic [15:0]   ds_left;
  logic [7:0]    cur_cat;
  logic [7:0]    cur_num;
  logic          found;
  status_t       fault;

  deframe_word_t expected_words[$];
  buffer_byte_t  pending_bytes[$];
  logic [7:0]    buf_bytes[$];
  logic [7:0]    block_body[$];

  int  mismatch_count = 0;
  int  words_checked = 0;
  int  bytes_sent = 0;
  int  buffers_sent = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  stall_next;
  int  calm_left = 0;
  logic byte_fire = 1'b0;
  logic result_fire = 1'b0;

  function automatic logic [7:0] sig_at(input int i);
    return SIG_TEXT[111 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] tag_at(input logic [1:0] i);
    return TAG_TEXT[31 - 8 * i -: 8];
  endfunction

  task automatic clear_parser();
    ph = S_SIGNATURE;
    fcount = '0;
    rid = '0;
    blk_left = '0;
    ds_left = '0;
    cur_cat = '0;
    cur_num = '0;
    found = 1'b0;
    fault = ST_FOUND;
  endtask

  task automatic push_word(input logic summ, input logic [7:0] pb, input logic pv,
                           input logic de, input status_t st);
    deframe_word_t w;
    w.summ = summ;
    w.cat = summ ? 8'h00 : cur_cat;
    w.num = summ ? 8'h00 : cur_num;
    w.data = pb;
    w.pv = pv;
    w.de = de;
    w.st = st;
    expected_words.push_back(w);
  endtask

  task automatic advance_block(input parser_phase_t nxt);
    blk_left = blk_left - 16'd1;
    if (blk_left == 16'd0) begin
      ph = S_TAG;
      fcount = '0;
    end else begin
      ph = nxt;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic eob);
    status_t st;
    logic    last;
    case (ph)
      S_SIGNATURE: begin
        if (fcount >= SigLen || b != sig_at(fcount)) begin
          fault = ST_BAD_SIG;
          ph = S_IGNORE;
        end else begin
          fcount++;
          if (fcount == SigLen) begin
            fcount = '0;
            ph = S_TAG;
          end
        end
      end
      S_TAG: begin
        if (b != tag_at(fcount[1:0])) begin
          ph = S_IGNORE;
        end else begin
          fcount++;
          if (fcount >= 4) begin
            fcount = '0;
            rid = '0;
            ph = S_ID;
          end
        end
      end
      S_ID: begin
        rid = {rid[7:0], b};
        fcount++;
        if (fcount >= 2) begin
          fcount = '0;
          ph = S_NAME_LEN;
        end
      end
      S_NAME_LEN: begin
        fcount = b | 8'h01;
        ph = S_NAME;
      end
      S_NAME: begin
        fcount--;
        if (fcount == 8'd0) begin
          blk_left = '0;
          ph = S_SIZE;
        end
      end
      S_SIZE: begin
        blk_left = {blk_left[7:0], b};
        fcount++;
        if (fcount >= 2) begin
          fcount = '0;
          if (rid == wanted_id) found = 1'b1;
          if (blk_left == 16'd0) ph = S_TAG;
          else ph = (rid == wanted_id) ? S_MARKER : S_SKIP;
        end
      end
      S_SKIP: advance_block(S_SKIP);
      S_MARKER: begin
        if (b != DATASET_MARKER) begin
          if (fault == ST_FOUND) fault = ST_MARKER;
          advance_block(S_SKIP);
        end else begin
          advance_block(S_CATEGORY);
        end
      end
      S_CATEGORY: begin
        cur_cat = b;
        advance_block(S_NUMBER);
      end
      S_NUMBER: begin
        cur_num = b;
        advance_block(S_LEN_HI);
      end
      S_LEN_HI: begin
        ds_left = {b, 8'h00};
        advance_block(S_LEN_LO);
      end
      S_LEN_LO: begin
        ds_left[7:0] = b;
        if (ds_left == 16'd0) begin
          push_word(1'b0, 8'h00, 1'b0, 1'b1, ST_FOUND);
          advance_block(S_MARKER);
        end else begin
          advance_block(S_DATA);
        end
      end
      S_DATA: begin
        ds_left = ds_left - 16'd1;
        last = (ds_left == 16'd0) || (blk_left == 16'd1);
        push_word(1'b0, b, 1'b1, last, ST_FOUND);
        advance_block((ds_left == 16'd0) ? S_MARKER : S_DATA);
      end
      default: ph = S_IGNORE;
    endcase

    if (eob) begin
      if (ph == S_SIGNATURE || fault == ST_BAD_SIG) st = ST_BAD_SIG;
      else if (fault == ST_MARKER) st = ST_MARKER;
      else if (found) st = ST_FOUND;
      else st = ST_NONE;
      push_word(1'b1, 8'h00, 1'b0, 1'b0, st);
      clear_parser();
    end
  endtask

  task automatic check_word();
    deframe_word_t w;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected");
      mismatch_count++;
    end else begin
      w = expected_words.pop_front();
      words_checked++;
      if (is_summary !== w.summ) begin
        $error("is_summary: expected %0h, actual %0h", w.summ, is_summary);
        mismatch_count++;
      end
      if (record_category !== w.cat) begin
        $error("record_category: expected %0h, actual %0h", w.cat, record_category);
        mismatch_count++;
      end
      if (dataset_number !== w.num) begin
        $error("dataset_number: expected %0h, actual %0h", w.num, dataset_number);
        mismatch_count++;
      end
      if (payload_byte !== w.data) begin
        $error("payload_byte: expected %0h, actual %0h", w.data, payload_byte);
        mismatch_count++;
      end
      if (payload_valid !== w.pv) begin
        $error("payload_valid: expected %0h, actual %0h", w.pv, payload_valid);
        mismatch_count++;
      end
      if (dataset_end !== w.de) begin
        $error("dataset_end: expected %0h, actual %0h", w.de, dataset_end);
        mismatch_count++;
      end
      if (parse_status !== w.st) begin
        $error("parse_status: expected %0h, actual %0h", w.st, parse_status);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    byte_fire <= byte_valid && byte_ready;
    result_fire <= result_valid && result_ready;
    if (!rst && byte_valid && byte_ready) deframe_byte(in_byte, end_of_buffer);
    if (!rst && result_valid && result_ready) check_word();
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 39) == 0) calm_left <= 30;
  end

  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_fire) begin
      if (send_gap > 0) begin
        byte_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        in_byte <= pending_bytes[0].b;
        end_of_buffer <= pending_bytes[0].eob;
        pending_bytes.pop_front();
        byte_valid <= 1'b1;
        send_gap <= (calm_left > 0) ? 0 : $urandom_range(0, 6);
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_fire) stall_next = (calm_left > 0) ? 0 : $urandom_range(0, 6);
      else stall_next = (recv_stall > 0) ? recv_stall - 1 : 0;
      recv_stall <= stall_next;
      result_ready <= (stall_next == 0);
    end
  end

  task automatic add_sig();
    for (int i = 0; i < SigLen; i++) buf_bytes.push_back(sig_at(i));
  endtask

  task automatic add_dataset(input logic [7:0] cat, input logic [7:0] num,
                             input logic [15:0] len, input int n_payload);
    block_body.push_back(DATASET_MARKER);
    block_body.push_back(cat);
    block_body.push_back(num);
    block_body.push_back(len[15:8]);
    block_body.push_back(len[7:0]);
    repeat (n_payload) block_body.push_back(8'($urandom));
  endtask

  task automatic add_block(input logic [15:0] id, input logic [7:0] name_len,
                           input logic [15:0] size);
    for (int i = 0; i < 4; i++) buf_bytes.push_back(tag_at(2'(i)));
    buf_bytes.push_back(id[15:8]);
    buf_bytes.push_back(id[7:0]);
    buf_bytes.push_back(name_len);
    repeat (int'(name_len | 8'h01)) buf_bytes.push_back(8'($urandom));
    buf_bytes.push_back(size[15:8]);
    buf_bytes.push_back(size[7:0]);
    foreach (block_body[i]) buf_bytes.push_back(block_body[i]);
    block_body.delete();
  endtask

  task automatic send_buffer();
    buffer_byte_t item;
    foreach (buf_bytes[i]) begin
      item.b = buf_bytes[i];
      item.eob = (i == buf_bytes.size() - 1);
      pending_bytes.push_back(item);
    end
    bytes_sent += buf_bytes.size();
    buffers_sent++;
    buf_bytes.delete();
  endtask

  task automatic make_random_buffer();
    int          kind;
    int          size;
    int          idx;
    int          len_pick;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  name_len;
    kind = $urandom_range(0, 99);
    add_sig();
    repeat ($urandom_range(1, 3)) begin
      id = ($urandom_range(0, 2) != 0) ? wanted_id : 16'($urandom);
      if (id == wanted_id) begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 19) == 0) block_body.push_back(8'($urandom));
          len_pick = $urandom_range(0, 9);
          if (len_pick == 0) len = 16'd0;
          else if (len_pick == 1) len = 16'($urandom);
          else len = 16'($urandom_range(1, 6));
          add_dataset(8'($urandom), 8'($urandom), len, (len > 16'd8) ? $urandom_range(0, 8)
                                                                     : int'(len));
        end
      end else begin
        repeat ($urandom_range(0, 8)) block_body.push_back(8'($urandom));
      end
      name_len = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      size = block_body.size();
      if ($urandom_range(0, 9) == 0 && size > 0) size = size - $urandom_range(1, size);
      add_block(id, name_len, 16'(size));
    end
    if (kind < 10) begin
      idx = $urandom_range(0, buf_bytes.size() - 1);
      buf_bytes[idx] = 8'($urandom);
    end else if (kind < 18) begin
      idx = $urandom_range(1, buf_bytes.size());
      buf_bytes = buf_bytes[0:idx-1];
    end else if (kind < 22) begin
      buf_bytes.delete();
      repeat ($urandom_range(1, 20)) buf_bytes.push_back(8'($urandom));
    end
    send_buffer();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_wanted_id(input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    wanted_id = value;
  endtask

  initial begin
    int          start_bytes;
    logic [15:0] setting;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    byte_valid = 1'b0;
    in_byte = '0;
    end_of_buffer = 1'b0;
    result_ready = 1'b0;
    wanted_id = WANTED_ID_RESET;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bad first signature byte
    buf_bytes.push_back(8'h00);
    send_buffer();
    // buffer ends inside the signature
    for (int i = 0; i < 5; i++) buf_bytes.push_back(sig_at(i));
    send_buffer();
    // signature only, nothing found
    add_sig();
    send_buffer();
    // broken block tag, rest ignored
    add_sig();
    buf_bytes.push_back(8'h38);
    buf_bytes.push_back(8'h42);
    buf_bytes.push_back(8'h49);
    buf_bytes.push_back(8'h58);
    buf_bytes.push_back(DATASET_MARKER);
    buf_bytes.push_back(8'hFF);
    send_buffer();
    // matching block of size zero
    add_sig();
    add_block(WANTED_ID_RESET, 8'h00, 16'd0);
    send_buffer();
    // empty dataset, extreme fields, then a missing marker
    add_sig();
    add_dataset(8'h02, 8'h00, 16'd0, 0);
    add_dataset(8'hFF, 8'hFF, 16'd2, 0);
    block_body.push_back(8'h00);
    block_body.push_back(8'hFF);
    block_body.push_back(8'h00);
    block_body.push_back(8'hAA);
    add_block(WANTED_ID_RESET, 8'h00, 16'(block_body.size()));
    repeat (2) block_body.push_back(8'($urandom));
    add_block(16'hFFFF, 8'h03, 16'd2);
    send_buffer();
    // block ends inside a payload, then inside a header
    add_sig();
    add_dataset(8'h01, 8'h05, 16'd5, 2);
    add_block(WANTED_ID_RESET, 8'h02, 16'(block_body.size()));
    block_body.push_back(DATASET_MARKER);
    block_body.push_back(8'h01);
    add_block(WANTED_ID_RESET, 8'hFF, 16'd2);
    send_buffer();
    wait_drained();

    for (int k = 0; k < 5; k++) begin
      case (k)
        1: setting = 16'h0000;
        2: setting = 16'hFFFF;
        3: setting = 16'($urandom);
        4: setting = WANTED_ID_RESET;
        default: setting = wanted_id;
      endcase
      if (k > 0) write_wanted_id(setting);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < BytesPerSetting) make_random_buffer();
      wait_drained();
    end

    $display("ran %0d buffers (%0d bytes) through five resource id settings", buffers_sent,
             bytes_sent);
    $display("checked %0d result words, %0d field mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> image_resource_iptc_deframer_core.f
rtl/iptcd_pkg.sv
rtl/iptcd_front.sv
rtl/iptcd_fifo.sv
rtl/iptcd_back.sv
rtl/image_resource_iptc_deframer_core.sv
tb/sv/image_resource_iptc_deframer_core_test.sv
